FILE: hdl/ssd_pkg.sv
// Shared types and constants for the seven-segment scan driver.
// Holds the item and result structs, mode and register codes and the character encoder.
// No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

    // Item modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_STATUS = 2'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_TIME       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMP_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMP_ENABLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_IN_USE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TUBES_IN_USE  = 3'd4;

    // Reset values and defaults substituted for a zero register
    localparam logic [15:0] DEF_ON_TIME   = 16'd200;
    localparam logic [7:0]  DEF_COMP_STEP = 8'd15;
    localparam logic [3:0]  RST_DIGITS    = 4'd8;
    localparam logic [2:0]  RST_TUBES     = 3'd4;

    // Segment bits: A is the MSB, DP the LSB
    localparam logic [7:0] SEG_A  = 8'h80;
    localparam logic [7:0] SEG_B  = 8'h40;
    localparam logic [7:0] SEG_C  = 8'h20;
    localparam logic [7:0] SEG_D  = 8'h10;
    localparam logic [7:0] SEG_E  = 8'h08;
    localparam logic [7:0] SEG_F  = 8'h04;
    localparam logic [7:0] SEG_G  = 8'h02;
    localparam logic [7:0] SEG_DP = 8'h01;

    localparam logic [7:0] DIGIT_PAT [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hE6
    };

    localparam logic [7:0] LETTER_PAT [26] = '{
        8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hF6, 8'h6E, 8'h0C, 8'h70,
        8'hAE, 8'h1C, 8'hF2, 8'h2A, 8'h3A, 8'hCE, 8'hE6, 8'h8C, 8'hB6, 8'h9E,
        8'h7C, 8'h46, 8'h7E, 8'hF6, 8'h76, 8'hDA
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] character;
        logic [1:0] tube;
        logic [2:0] position;
    } item_t;

    typedef struct packed {
        logic [31:0] segments;
        logic [2:0]  digit_index;
        logic        digit_enable;
    } result_t;

    // Character code to segment byte; unknown codes give blank
    function automatic logic [7:0] encode_char(input logic [7:0] ch);
        logic [7:0] off;
        logic [7:0] pat;
        off = 8'd0;
        pat = 8'h00;
        if (ch <= 8'd9) begin
            pat = DIGIT_PAT[ch[3:0]];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            off = ch - 8'h61;
            pat = LETTER_PAT[off[4:0]];
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            off = ch - 8'h41;
            pat = LETTER_PAT[off[4:0]];
        end else if (ch == 8'h2E) begin
            pat = SEG_DP;
        end else if (ch == 8'h2D) begin
            pat = SEG_G;
        end else if (ch == 8'h3D) begin
            pat = SEG_D | SEG_G;
        end
        return pat;
    endfunction

endpackage

FILE: hdl/ssd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module ssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/seven_segment_scan_driver_core.sv
// Seven-segment scan driver, top level.
// Depends on ssd_pkg (types, codes, encoder) and ssd_ram (segment store banks).
`timescale 1ns / 1ps

// The block takes one item per clock unless stalled and returns one result
// per item through an output register. Write items store a character's
// segment pattern at a tube and digit position, clear items blank the whole
// store, tick items move the scan. Every result shows the segments of the
// selected digit (tubes past tubes_in_use read zero), its index, and whether
// it is driven on. The segment store sits in one RAM bank per tube, read
// through a registered port at the digit that the scan will select next;
// per-entry valid bits clear and reset the store at once, so no clearing
// pass follows reset. Items stall while a held result is not taken, and a
// tick that finds the selected digit at or past digits_in_use (after that
// register was lowered) stalls while the scan restarts at digit zero and the RAM read is reissued there.

module seven_segment_scan_driver_core #(
    parameter int MAX_TUBES  = 4,
    parameter int MAX_DIGITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // item channel
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  ssd_pkg::item_t                         item,
    // result channel
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output ssd_pkg::result_t                       result,
    // configuration port
    input  logic                                   cfg_write,
    input  logic [ssd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int TW = (MAX_TUBES > 1) ? $clog2(MAX_TUBES) : 1;

    // Configuration registers
    logic [15:0] on_time_reg;
    logic [7:0]  comp_step_reg;
    logic        comp_enable_reg;
    logic [3:0]  digits_in_use_reg;
    logic [2:0]  tubes_in_use_reg;

    // Scan state
    logic [DW-1:0] scan_reg, scan_next;
    logic [15:0]   dwell_reg, dwell_next;

    // Per-entry valid bits: an entry without one reads blank
    logic [MAX_TUBES-1:0] valid_reg [MAX_DIGITS];

    // Last write transfer, patched onto the RAM data read at the same edge
    logic          fwd_valid_reg;
    logic [DW-1:0] fwd_pos_reg;
    logic [TW-1:0] fwd_tube_reg;
    logic [7:0]    fwd_byte_reg;

    // Output register
    logic                result_valid_reg;
    ssd_pkg::result_t    result_reg, result_next;

    logic          accept;
    logic          restart;
    logic          is_write, is_clear, is_tick;
    logic          write_in_range;
    logic [DW-1:0] pos_addr;
    logic [TW-1:0] tube_addr;
    logic [7:0]    write_byte;

    logic [4:0]    eff_digits;
    logic [3:0]    eff_tubes;
    logic [4:0]    scan_inc;
    logic [DW-1:0] scan_adv;

    logic [7:0]    bank_rd   [MAX_TUBES];
    logic [7:0]    row_base  [MAX_TUBES];
    logic [7:0]    row_shown [MAX_TUBES];
    logic [3:0]    blanks;
    logic [15:0]   on_eff;
    logic [7:0]    step_eff;
    logic [11:0]   comp_sub;
    logic [15:0]   dwell_load;
    logic [15:0]   dwell_cur;
    logic [31:0]   seg_word;
    logic          enable;

    // ---------------------------------------------------------------------
    // Item decode and handshake
    // ---------------------------------------------------------------------
    assign is_write = (item.mode == ssd_pkg::MODE_WRITE);
    assign is_clear = (item.mode == ssd_pkg::MODE_CLEAR);
    assign is_tick  = (item.mode == ssd_pkg::MODE_TICK);

    assign pos_addr       = DW'(item.position);
    assign tube_addr      = TW'(item.tube);
    assign write_in_range = (5'(item.position) < 5'(MAX_DIGITS))
                         && (4'(item.tube) < 4'(MAX_TUBES));
    assign write_byte     = ssd_pkg::encode_char(item.character);

    // Clamp the count registers to their usable ranges
    always_comb
    begin
        if (digits_in_use_reg == 4'd0)
        begin
            eff_digits = 5'd1;
        end
        else if (5'(digits_in_use_reg) > 5'(MAX_DIGITS))
        begin
            eff_digits = 5'(MAX_DIGITS);
        end
        else
        begin
            eff_digits = 5'(digits_in_use_reg);
        end

        if (tubes_in_use_reg == 3'd0)
        begin
            eff_tubes = 4'd1;
        end
        else if (4'(tubes_in_use_reg) > 4'(MAX_TUBES))
        begin
            eff_tubes = 4'(MAX_TUBES);
        end
        else
        begin
            eff_tubes = 4'(tubes_in_use_reg);
        end
    end

    // A tick that finds the scan at or past the digit count stalls while
    // the scan restarts at zero and the row of digit zero is fetched.
    assign restart    = item_valid && is_tick && (5'(scan_reg) >= eff_digits);
    assign item_stall = (result_valid_reg && result_stall) || restart;
    assign accept     = item_valid && !item_stall;

    // ---------------------------------------------------------------------
    // Segment store: one bank per tube, row address is the digit
    // ---------------------------------------------------------------------
    genvar gk;
    generate
        for (gk = 0; gk < MAX_TUBES; gk++)
        begin : g_bank
            ssd_ram #(
                .WIDTH (8),
                .DEPTH (MAX_DIGITS)
            ) u_bank (
                .clk   (clk),
                .we    (accept && is_write && write_in_range && (tube_addr == TW'(gk))),
                .waddr (pos_addr),
                .wdata (write_byte),
                .raddr (scan_next),
                .rdata (bank_rd[gk])
            );
        end
    endgenerate

    // Row of the selected digit as the store holds it now: patch the write
    // that landed with the read, then drop entries that are not valid.
    always_comb
    begin
        for (int k = 0; k < MAX_TUBES; k++)
        begin
            row_base[k] = bank_rd[k];
            if (fwd_valid_reg && (fwd_pos_reg == scan_reg) && (fwd_tube_reg == TW'(k)))
            begin
                row_base[k] = fwd_byte_reg;
            end
            if (!valid_reg[scan_reg][k])
            begin
                row_base[k] = 8'h00;
            end

            // The item's own write or clear shows in its result
            row_shown[k] = row_base[k];
            if (is_clear)
            begin
                row_shown[k] = 8'h00;
            end
            else if (is_write && write_in_range && (pos_addr == scan_reg)
                     && (tube_addr == TW'(k)))
            begin
                row_shown[k] = write_byte;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Dwell for the selected digit
    // ---------------------------------------------------------------------
    always_comb
    begin
        blanks = 4'd0;
        for (int k = 0; k < MAX_TUBES; k++)
        begin
            if ((4'(k) < eff_tubes) && (row_base[k] == 8'h00))
            begin
                blanks = blanks + 4'd1;
            end
        end

        on_eff   = (on_time_reg == 16'd0) ? ssd_pkg::DEF_ON_TIME : on_time_reg;
        step_eff = (comp_step_reg == 8'd0) ? ssd_pkg::DEF_COMP_STEP : comp_step_reg;
        comp_sub = 12'(blanks) * 12'(step_eff);

        if (!comp_enable_reg)
        begin
            dwell_load = on_eff;
        end
        else if (on_eff > 16'(comp_sub))
        begin
            dwell_load = on_eff - 16'(comp_sub);
        end
        else
        begin
            dwell_load = 16'd0;
        end
    end

    // ---------------------------------------------------------------------
    // Scan control and result
    // ---------------------------------------------------------------------
    assign scan_inc = 5'(scan_reg) + 5'd1;
    assign scan_adv = (scan_inc >= eff_digits) ? '0 : DW'(scan_inc);
    assign dwell_cur = (dwell_reg == 16'd0) ? dwell_load : dwell_reg;

    always_comb
    begin
        scan_next  = scan_reg;
        dwell_next = dwell_reg;
        enable     = (dwell_reg != 16'd0);

        if (restart)
        begin
            // Restart at digit zero with a fresh dwell
            scan_next  = '0;
            dwell_next = 16'd0;
        end
        else if (accept && is_tick)
        begin
            if (dwell_cur == 16'd0)
            begin
                // Zero dwell: one dark tick, then skip ahead
                enable     = 1'b0;
                dwell_next = 16'd0;
                scan_next  = scan_adv;
            end
            else
            begin
                enable     = 1'b1;
                dwell_next = dwell_cur - 16'd1;
                if (dwell_cur == 16'd1)
                begin
                    scan_next = scan_adv;
                end
            end
        end
    end

    // Pack the low tubes into the segment word; unused tubes read zero
    always_comb
    begin
        seg_word = 32'd0;
        for (int k = 0; k < 4; k++)
        begin
            if ((k < MAX_TUBES) && (4'(k) < eff_tubes))
            begin
                seg_word[8*k +: 8] = row_shown[(k < MAX_TUBES) ? k : 0];
            end
        end

        result_next.segments     = seg_word;
        result_next.digit_index  = 3'(scan_reg);
        result_next.digit_enable = enable;
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg       <= ssd_pkg::DEF_ON_TIME;
            comp_step_reg     <= ssd_pkg::DEF_COMP_STEP;
            comp_enable_reg   <= 1'b1;
            digits_in_use_reg <= ssd_pkg::RST_DIGITS;
            tubes_in_use_reg  <= ssd_pkg::RST_TUBES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssd_pkg::CFG_ON_TIME:       on_time_reg       <= cfg_data;
                ssd_pkg::CFG_COMP_STEP:     comp_step_reg     <= cfg_data[7:0];
                ssd_pkg::CFG_COMP_ENABLE:   comp_enable_reg   <= cfg_data[0];
                ssd_pkg::CFG_DIGITS_IN_USE: digits_in_use_reg <= cfg_data[3:0];
                ssd_pkg::CFG_TUBES_IN_USE:  tubes_in_use_reg  <= cfg_data[2:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            dwell_reg     <= 16'd0;
            fwd_valid_reg <= 1'b0;
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                valid_reg[d] <= '0;
            end
        end
        else
        begin
            scan_reg      <= scan_next;
            dwell_reg     <= dwell_next;
            fwd_valid_reg <= accept && is_write && write_in_range;
            if (accept && is_clear)
            begin
                for (int d = 0; d < MAX_DIGITS; d++)
                begin
                    valid_reg[d] <= '0;
                end
            end
            else if (accept && is_write && write_in_range)
            begin
                valid_reg[pos_addr][tube_addr] <= 1'b1;
            end
        end
    end

    // Forwarded write payload
    always_ff @(posedge clk)
    begin
        if (accept && is_write && write_in_range)
        begin
            fwd_pos_reg  <= pos_addr;
            fwd_tube_reg <= tube_addr;
            fwd_byte_reg <= write_byte;
        end
    end

    // Output register: load on a transfer in, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
